/* hw/rtl/source_char_tokenizer_top_assert.svh */
// Assertion macros for the source character tokenizer.
`ifndef SOURCE_CHAR_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_CHAR_TOKENIZER_TOP_ASSERT_SVH

// Check that cond holds at every edge where trig is high.
`define STK_ASSERT_IMP(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that cond holds in the cycle after trig.
`define STK_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hw/rtl/stk_pkg.sv */
// Package: shared types, codes and character classes of the tokenizer.
package stk_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        M_IDLE, M_QUEST, M_BANG, M_LT, M_GT, M_HASH, M_LINE,
        M_BLOCK, M_INT, M_INTDOT, M_DEC, M_IDENT, M_STR
    } mode_t;

    localparam logic [4:0] K_SEMI   = 5'd0;
    localparam logic [4:0] K_COMMA  = 5'd1;
    localparam logic [4:0] K_COLON  = 5'd2;
    localparam logic [4:0] K_DOT    = 5'd3;
    localparam logic [4:0] K_LPAR   = 5'd4;
    localparam logic [4:0] K_RPAR   = 5'd5;
    localparam logic [4:0] K_LBRACE = 5'd6;
    localparam logic [4:0] K_RBRACE = 5'd7;
    localparam logic [4:0] K_PLUS   = 5'd8;
    localparam logic [4:0] K_MINUS  = 5'd9;
    localparam logic [4:0] K_STAR   = 5'd10;
    localparam logic [4:0] K_SLASH  = 5'd11;
    localparam logic [4:0] K_PCT    = 5'd12;
    localparam logic [4:0] K_ASSIGN = 5'd13;
    localparam logic [4:0] K_EQ     = 5'd14;
    localparam logic [4:0] K_NE     = 5'd15;
    localparam logic [4:0] K_LT     = 5'd16;
    localparam logic [4:0] K_LE     = 5'd17;
    localparam logic [4:0] K_GT     = 5'd18;
    localparam logic [4:0] K_GE     = 5'd19;
    localparam logic [4:0] K_INT    = 5'd20;
    localparam logic [4:0] K_DEC    = 5'd21;
    localparam logic [4:0] K_STR    = 5'd22;
    localparam logic [4:0] K_IDENT  = 5'd23;
    localparam logic [4:0] K_EOF    = 5'd24;
    localparam logic [4:0] K_ERR    = 5'd25;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_QUEST  = 3'd1;
    localparam logic [2:0] E_BANG   = 3'd2;
    localparam logic [2:0] E_UNEXP  = 3'd3;
    localparam logic [2:0] E_STR    = 3'd4;
    localparam logic [2:0] E_ESC    = 3'd5;
    localparam logic [2:0] E_BLOCK  = 3'd6;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_UND   = 8'h5F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {ACT_SKIP, ACT_NL, ACT_EMIT, ACT_BEGIN, ACT_ERR} act_t;

    typedef struct packed {
        act_t       act;
        logic [4:0] kind;
        mode_t      mode;
    } idle_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [2:0]  err;
        logic [31:0] pos;
        logic [15:0] len;
    } tok_t;

    typedef struct packed {
        logic [1:0]       cnt;
        logic [31:0]      line;
        tok_t [2:0]       toks;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic tok_t mk_tok(logic [4:0] kind, logic [2:0] err,
                                    logic [31:0] pos, logic [15:0] len);
        tok_t t;
        t.kind = kind;
        t.err  = err;
        t.pos  = pos;
        t.len  = len;
        return t;
    endfunction

    function automatic logic [15:0] sat_inc(logic [15:0] l);
        return (l == LEN_MAX) ? l : l + 16'd1;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UND;
    endfunction

    function automatic logic is_escape(logic [7:0] c);
        return c == 8'h61 || c == 8'h62 || c == 8'h66 || c == 8'h6E || c == 8'h72 ||
               c == 8'h74 || c == 8'h76 || c == CH_BSL || c == 8'h27 ||
               c == CH_QUOTE || c == CH_0;
    endfunction

    // Classify a character seen between tokens.
    function automatic idle_t idle_scan(logic [7:0] c);
        idle_t r;
        r.act  = ACT_EMIT;
        r.kind = K_SEMI;
        r.mode = M_IDLE;
        case (c)
            8'h3B: r.kind = K_SEMI;
            8'h2C: r.kind = K_COMMA;
            8'h3A: r.kind = K_COLON;
            CH_DOT: r.kind = K_DOT;
            8'h28: r.kind = K_LPAR;
            8'h29: r.kind = K_RPAR;
            8'h7B: r.kind = K_LBRACE;
            8'h7D: r.kind = K_RBRACE;
            8'h2B: r.kind = K_PLUS;
            8'h2D: r.kind = K_MINUS;
            8'h2A: r.kind = K_STAR;
            8'h2F: r.kind = K_SLASH;
            8'h25: r.kind = K_PCT;
            CH_EQ: r.kind = K_ASSIGN;
            CH_QUEST: begin r.act = ACT_BEGIN; r.mode = M_QUEST; end
            CH_BANG:  begin r.act = ACT_BEGIN; r.mode = M_BANG; end
            8'h3C:    begin r.act = ACT_BEGIN; r.mode = M_LT; end
            8'h3E:    begin r.act = ACT_BEGIN; r.mode = M_GT; end
            CH_HASH:  begin r.act = ACT_BEGIN; r.mode = M_HASH; end
            CH_QUOTE: begin r.act = ACT_BEGIN; r.mode = M_STR; end
            8'h20, 8'h0D, 8'h09: r.act = ACT_SKIP;
            CH_NL: r.act = ACT_NL;
            default:
            begin
                if (is_digit(c)) begin r.act = ACT_BEGIN; r.mode = M_INT; end
                else if (is_alpha(c)) begin r.act = ACT_BEGIN; r.mode = M_IDENT; end
                else r.act = ACT_ERR;
            end
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/stk_front.sv */
// Front end: scanner state machine, packs the tokens of one character into a bundle.
module stk_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       ch,
    input  logic             end_of_source,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_data,
    output logic             push,
    output stk_pkg::bundle_t bundle
);

    stk_pkg::mode_t mode_reg, mode_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] line_reg, line_next;
    logic [31:0] sl_reg;
    logic        esc_reg, esc_next;
    logic        hash_reg, hash_next;
    logic [15:0] len_reg, len_next;

    logic [1:0]       e;
    logic             run_idle;
    stk_pkg::idle_t   ic;
    stk_pkg::bundle_t b;

    always_comb
    begin
        mode_next = mode_reg;
        ts_next   = ts_reg;
        off_next  = off_reg + 32'd1;
        line_next = line_reg;
        esc_next  = esc_reg;
        hash_next = hash_reg;
        len_next  = len_reg;
        run_idle  = 1'b0;
        e         = 2'd0;
        b         = '0;
        b.line    = line_reg;
        ic        = stk_pkg::idle_scan(ch);
        if (end_of_source)
        begin
            // flush the pending token, then EOF, then restart
            case (mode_reg)
                stk_pkg::M_QUEST:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_ERR, stk_pkg::E_QUEST, ts_reg, 16'd1);
                    e = e + 2'd1;
                end
                stk_pkg::M_BANG:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_ERR, stk_pkg::E_BANG, ts_reg, 16'd1);
                    e = e + 2'd1;
                end
                stk_pkg::M_LT:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_LT, stk_pkg::E_NONE, ts_reg, 16'd1);
                    e = e + 2'd1;
                end
                stk_pkg::M_GT:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_GT, stk_pkg::E_NONE, ts_reg, 16'd1);
                    e = e + 2'd1;
                end
                stk_pkg::M_BLOCK:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_ERR, stk_pkg::E_BLOCK, ts_reg, len_reg);
                    e = e + 2'd1;
                end
                stk_pkg::M_INT:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_INT, stk_pkg::E_NONE, ts_reg, len_reg);
                    e = e + 2'd1;
                end
                stk_pkg::M_INTDOT:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_INT, stk_pkg::E_NONE, ts_reg, len_reg);
                    e = e + 2'd1;
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_DOT, stk_pkg::E_NONE,
                                                off_reg - 32'd1, 16'd1);
                    e = e + 2'd1;
                end
                stk_pkg::M_DEC:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_DEC, stk_pkg::E_NONE, ts_reg, len_reg);
                    e = e + 2'd1;
                end
                stk_pkg::M_IDENT:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_IDENT, stk_pkg::E_NONE, ts_reg, len_reg);
                    e = e + 2'd1;
                end
                stk_pkg::M_STR:
                begin
                    b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_ERR, stk_pkg::E_STR, ts_reg, len_reg);
                    e = e + 2'd1;
                end
                default: ;
            endcase
            b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_EOF, stk_pkg::E_NONE, off_reg, 16'd0);
            e = e + 2'd1;
            mode_next = stk_pkg::M_IDLE;
            ts_next   = '0;
            off_next  = '0;
            line_next = sl_reg;
            esc_next  = 1'b0;
            hash_next = 1'b0;
            len_next  = '0;
        end
        else
        begin
            case (mode_reg)
                stk_pkg::M_QUEST, stk_pkg::M_BANG:
                begin
                    if (ch == stk_pkg::CH_EQ)
                    begin
                        b.toks[e] = stk_pkg::mk_tok((mode_reg == stk_pkg::M_QUEST) ?
                            stk_pkg::K_EQ : stk_pkg::K_NE, stk_pkg::E_NONE, ts_reg, 16'd2);
                        e = e + 2'd1;
                        mode_next = stk_pkg::M_IDLE;
                    end
                    else
                    begin
                        b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_ERR, (mode_reg == stk_pkg::M_QUEST) ?
                            stk_pkg::E_QUEST : stk_pkg::E_BANG, ts_reg, 16'd1);
                        e = e + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                stk_pkg::M_LT, stk_pkg::M_GT:
                begin
                    if (ch == stk_pkg::CH_EQ)
                    begin
                        b.toks[e] = stk_pkg::mk_tok((mode_reg == stk_pkg::M_LT) ?
                            stk_pkg::K_LE : stk_pkg::K_GE, stk_pkg::E_NONE, ts_reg, 16'd2);
                        e = e + 2'd1;
                        mode_next = stk_pkg::M_IDLE;
                    end
                    else
                    begin
                        b.toks[e] = stk_pkg::mk_tok((mode_reg == stk_pkg::M_LT) ?
                            stk_pkg::K_LT : stk_pkg::K_GT, stk_pkg::E_NONE, ts_reg, 16'd1);
                        e = e + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                stk_pkg::M_HASH:
                begin
                    if (ch == stk_pkg::CH_HASH)
                    begin
                        len_next  = stk_pkg::sat_inc(len_reg);
                        mode_next = stk_pkg::M_BLOCK;
                        hash_next = 1'b0;
                    end
                    else if (ch == stk_pkg::CH_NL) run_idle = 1'b1;
                    else mode_next = stk_pkg::M_LINE;
                end
                stk_pkg::M_LINE:
                begin
                    if (ch == stk_pkg::CH_NL) run_idle = 1'b1;
                end
                stk_pkg::M_BLOCK:
                begin
                    len_next = stk_pkg::sat_inc(len_reg);
                    if (ch == stk_pkg::CH_NL) line_next = line_reg + 32'd1;
                    if (ch == stk_pkg::CH_HASH && hash_reg)
                    begin
                        mode_next = stk_pkg::M_IDLE;
                        hash_next = 1'b0;
                    end
                    else hash_next = (ch == stk_pkg::CH_HASH);
                end
                stk_pkg::M_INT:
                begin
                    if (stk_pkg::is_digit(ch)) len_next = stk_pkg::sat_inc(len_reg);
                    else if (ch == stk_pkg::CH_DOT) mode_next = stk_pkg::M_INTDOT;
                    else
                    begin
                        b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_INT, stk_pkg::E_NONE, ts_reg, len_reg);
                        e = e + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                stk_pkg::M_INTDOT:
                begin
                    if (stk_pkg::is_digit(ch))
                    begin
                        len_next  = stk_pkg::sat_inc(stk_pkg::sat_inc(len_reg));
                        mode_next = stk_pkg::M_DEC;
                    end
                    else
                    begin
                        b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_INT, stk_pkg::E_NONE, ts_reg, len_reg);
                        e = e + 2'd1;
                        b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_DOT, stk_pkg::E_NONE,
                                                    off_reg - 32'd1, 16'd1);
                        e = e + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                stk_pkg::M_DEC, stk_pkg::M_IDENT:
                begin
                    if (stk_pkg::is_digit(ch) ||
                        (mode_reg == stk_pkg::M_IDENT && stk_pkg::is_alpha(ch)))
                        len_next = stk_pkg::sat_inc(len_reg);
                    else
                    begin
                        b.toks[e] = stk_pkg::mk_tok((mode_reg == stk_pkg::M_DEC) ?
                            stk_pkg::K_DEC : stk_pkg::K_IDENT, stk_pkg::E_NONE, ts_reg, len_reg);
                        e = e + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                stk_pkg::M_STR:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        len_next = stk_pkg::sat_inc(len_reg);
                        if (!stk_pkg::is_escape(ch))
                        begin
                            b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_ERR, stk_pkg::E_ESC,
                                                        off_reg - 32'd1, 16'd2);
                            e = e + 2'd1;
                            if (ch == stk_pkg::CH_NL) line_next = line_reg + 32'd1;
                        end
                    end
                    else if (ch == stk_pkg::CH_QUOTE)
                    begin
                        b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_STR, stk_pkg::E_NONE, ts_reg,
                                                    stk_pkg::sat_inc(len_reg));
                        e = e + 2'd1;
                        len_next  = stk_pkg::sat_inc(len_reg);
                        mode_next = stk_pkg::M_IDLE;
                    end
                    else if (ch == stk_pkg::CH_NL)
                    begin
                        b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_ERR, stk_pkg::E_STR, ts_reg, len_reg);
                        e = e + 2'd1;
                        run_idle = 1'b1;
                    end
                    else
                    begin
                        len_next = stk_pkg::sat_inc(len_reg);
                        if (ch == stk_pkg::CH_BSL) esc_next = 1'b1;
                    end
                end
                default: run_idle = 1'b1;
            endcase
            // rescan the character from between tokens
            if (run_idle)
            begin
                mode_next = stk_pkg::M_IDLE;
                case (ic.act)
                    stk_pkg::ACT_EMIT:
                    begin
                        b.toks[e] = stk_pkg::mk_tok(ic.kind, stk_pkg::E_NONE, off_reg, 16'd1);
                        e = e + 2'd1;
                    end
                    stk_pkg::ACT_ERR:
                    begin
                        b.toks[e] = stk_pkg::mk_tok(stk_pkg::K_ERR, stk_pkg::E_UNEXP,
                                                    off_reg, 16'd1);
                        e = e + 2'd1;
                    end
                    stk_pkg::ACT_BEGIN:
                    begin
                        ts_next   = off_reg;
                        len_next  = 16'd1;
                        mode_next = ic.mode;
                        if (ic.mode == stk_pkg::M_STR) esc_next = 1'b0;
                    end
                    stk_pkg::ACT_NL: line_next = line_reg + 32'd1;
                    default: ;
                endcase
            end
        end
        b.cnt = e;
    end

    assign push   = take && (e != 2'd0);
    assign bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stk_pkg::M_IDLE;
            ts_reg   <= '0;
            off_reg  <= '0;
            line_reg <= 32'd1;
            sl_reg   <= 32'd1;
            esc_reg  <= 1'b0;
            hash_reg <= 1'b0;
            len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            sl_reg   <= cfg_data;
            line_reg <= cfg_data;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            ts_reg   <= ts_next;
            off_reg  <= off_next;
            line_reg <= line_next;
            esc_reg  <= esc_next;
            hash_reg <= hash_next;
            len_reg  <= len_next;
        end
    end

endmodule

/* hw/rtl/stk_queue.sv */
// Queue of token bundles between the scanner and the output stage.
module stk_queue #(
    parameter int DEPTH = stk_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stk_pkg::bundle_t wr_data,
    input  logic             pop,
    output stk_pkg::bundle_t rd_data,
    output stk_pkg::q_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    stk_pkg::bundle_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    function automatic logic [AW-1:0] adv(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push) mem[wp_reg] <= wr_data;
    end

    assign rd_data    = mem[rp_reg];
    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= adv(wp_reg);
            if (pop) rp_reg <= adv(rp_reg);
            if (push && !pop) cnt_reg <= cnt_reg + CW'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

/* hw/rtl/stk_back.sv */
// Back end: walks the tokens of the head bundle into the output register.
module stk_back (
    input  logic             clk,
    input  logic             rst_n,
    input  stk_pkg::bundle_t head,
    input  logic             head_valid,
    output logic             pop,
    input  logic             out_stall,
    output logic             out_valid,
    output stk_pkg::tok_t    out_tok,
    output logic [31:0]      out_line,
    output logic             out_last
);

    logic [1:0] sub_reg;
    logic       ov_reg;
    logic       load, at_end;

    assign load   = head_valid && (!ov_reg || !out_stall);
    assign at_end = (sub_reg == head.cnt - 2'd1);
    assign pop    = load && at_end;
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (load) sub_reg <= at_end ? 2'd0 : sub_reg + 2'd1;
            if (load) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_tok  <= head.toks[sub_reg];
            out_line <= head.line;
            out_last <= at_end;
        end
    end

endmodule

/* hw/rtl/source_char_tokenizer_top.sv */
// Top level of the source character tokenizer: scanner, bundle queue, output stage.
// Takes one character per cycle while in_stall is low; the tokens of a character pass
// through the bundle queue into the output register, and each token leaves the output
// register in a cycle of its own. Characters that end up to three tokens fill the queue
// and stall input when those bursts come faster than the output stage drains them at one
// token per cycle while out_stall is low; a start_line write also holds input for its cycle.
// Reset (rst_n low, asynchronous) empties the queue and the output register and
// sets start_line and the line count to 1.
`include "source_char_tokenizer_top_assert.svh"

module source_char_tokenizer_top #(
    parameter int QDEPTH = stk_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // character channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        end_of_source,
    // start_line write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // token channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  kind,
    output logic [2:0]  error_code,
    output logic [31:0] start_pos,
    output logic [15:0] lexeme_length,
    output logic [31:0] line_number,
    output logic        last
);

    stk_pkg::bundle_t wr_bundle, head;
    stk_pkg::q_stat_t q_stat;
    stk_pkg::tok_t    tok;
    logic             take, q_push, q_pop;

    // The scanner advances only while the queue has room for its bundle; hold
    // the character while a start_line write owns the scanner state.
    assign in_stall  = q_stat.full || cfg_valid;
    assign take      = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    stk_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .ch            (ch),
        .end_of_source (end_of_source),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .push          (q_push),
        .bundle        (wr_bundle)
    );

    stk_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (wr_bundle),
        .pop     (q_pop),
        .rd_data (head),
        .stat    (q_stat)
    );

    // Drain each bundle one token per transaction; last marks its final token.
    stk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (q_pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_tok    (tok),
        .out_line   (line_number),
        .out_last   (last)
    );

    assign kind          = tok.kind;
    assign error_code    = tok.err;
    assign start_pos     = tok.pos;
    assign lexeme_length = tok.len;

    `STK_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full, "bundle pushed into a full queue")
    `STK_ASSERT_IMP(a_err_code, out_valid,
        (kind == stk_pkg::K_ERR) == (error_code != stk_pkg::E_NONE), "bad error code")
    `STK_ASSERT_IMP(a_eof_len, out_valid && kind == stk_pkg::K_EOF,
        lexeme_length == 16'd0 && last, "EOF token malformed")
    `STK_ASSERT_NEXT(a_pop_valid, q_pop, out_valid, "bundle popped without output")

endmodule
